// ----- rtl/lerm_pkg.sv -----
// Shared types and constants for the link error-rate anomaly monitor.
package lerm_pkg;

	// Field and register widths fixed by the interface.
	localparam int WIN_W      = 16;
	localparam int PCT_W      = 7;
	localparam int OUTCOME_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;

	// Percent scale and number of quotient bits the divider resolves.
	localparam int PCT_SCALE = 100;
	localparam int QUO_STEPS = 7;
	localparam int STEP_W    = 3;

	// Parse outcome codes.
	localparam logic [OUTCOME_W-1:0] OUTCOME_INCOMPLETE = 2'd0;
	localparam logic [OUTCOME_W-1:0] OUTCOME_GOOD       = 2'd1;
	localparam logic [OUTCOME_W-1:0] OUTCOME_BAD        = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_PACKETS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_THRESH   = 1'd1;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COUNT,
		ST_DIVIDE,
		ST_EVAL,
		ST_DONE
	} state_t;

endpackage

// ----- rtl/lerm_div.sv -----
// Serial restoring divider that resolves one quotient bit per cycle.
module lerm_div #(
	parameter int COUNT_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [COUNT_BITS+lerm_pkg::PCT_W-1:0] dividend,
	input  logic [COUNT_BITS-1:0]           divisor,
	output logic                            done,
	output logic [lerm_pkg::PCT_W-1:0]      quotient
);
	import lerm_pkg::*;

	localparam int W = COUNT_BITS + PCT_W;

	logic [W-1:0]      rem_q;
	logic [W-1:0]      dsr_q;
	logic [PCT_W-1:0]  quo_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic              ge;
	logic [W-1:0]      diff;

	// The shared compare and subtract.
	assign ge   = (rem_q >= dsr_q);
	assign diff = rem_q - dsr_q;

	// Control: step counter, busy and done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(QUO_STEPS - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	// Datapath: the divisor starts aligned to the top quotient bit and shifts right.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsr_q <= W'(divisor) << (QUO_STEPS - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= diff;
			end
			quo_q <= {quo_q[PCT_W-2:0], ge};
			dsr_q <= dsr_q >> 1;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- rtl/link_error_rate_anomaly_monitor_top.sv -----
// Top level of the link error-rate anomaly monitor.
//
// Each input word is one parse outcome. An incomplete outcome is accepted and then loads
// the result register. A good or bad packet is accepted, then updates the saturating counts
// and forms errors times 100, then runs through the serial divider (seven steps that each
// resolve one bit of the percentage and a final one in which it signals done), then
// evaluates the window, and then loads the result register. The input is ready again only
// once the previous result has moved to the output register, so while the consumer does
// not stall the divider sets the packet rate. The result register lets a finished result
// wait for the consumer while the next word is accepted. Configuration writes are taken at
// any time and have no wait.
module link_error_rate_anomaly_monitor_top #(
	parameter int COUNT_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lerm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lerm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [lerm_pkg::OUTCOME_W-1:0]    outcome,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              anomaly,
	output logic                              new_alert,
	output logic [lerm_pkg::PCT_W-1:0]        error_percent
);
	import lerm_pkg::*;

	localparam int PROD_W = COUNT_BITS + PCT_W;
	localparam int CMP_W  = (COUNT_BITS > WIN_W) ? COUNT_BITS : WIN_W;

	state_t state_q, state_d;

	logic [WIN_W-1:0]      window_q;
	logic [PCT_W-1:0]      thresh_q;
	logic [COUNT_BITS-1:0] packet_q;
	logic [COUNT_BITS-1:0] error_q;
	logic [PCT_W-1:0]      rate_q;
	logic                  flag_q;
	logic                  rose_q;
	logic                  is_bad_q;
	logic                  out_valid_q;
	logic                  out_anom_q;
	logic                  out_rose_q;
	logic [PCT_W-1:0]      out_pct_q;

	logic                  in_acc;
	logic                  out_free;
	logic [COUNT_BITS-1:0] packet_inc;
	logic [COUNT_BITS-1:0] error_inc;
	logic [PROD_W-1:0]     err_ext;
	logic [PROD_W-1:0]     product;
	logic                  div_start;
	logic                  div_done;
	logic [PCT_W-1:0]      div_quo;
	logic                  window_full;
	logic [CMP_W-1:0]      half_ext;
	logic [CMP_W-1:0]      count_max_ext;
	logic [COUNT_BITS-1:0] half_c;
	logic                  flag_new;

	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WIN_W'(100);
			thresh_q <= PCT_W'(20);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_PACKETS: window_q <= cfg_data[WIN_W-1:0];
				REG_ERROR_THRESH:   thresh_q <= cfg_data[PCT_W-1:0];
				default: ;
			endcase
		end
	end

	// Saturating count increments and errors times 100 as a sum of shifts.
	assign packet_inc = (packet_q == '1) ? packet_q : packet_q + 1'b1;
	assign error_inc  = (!is_bad_q || error_q == '1) ? error_q : error_q + 1'b1;
	assign err_ext    = PROD_W'(error_inc);
	assign product    = (err_ext << 6) + (err_ext << 5) + (err_ext << 2);

	// Window test and slide target, limited to the counter range.
	assign window_full   = (CMP_W'(packet_q) >= CMP_W'(window_q));
	assign half_ext      = CMP_W'(window_q >> 1);
	assign count_max_ext = CMP_W'({COUNT_BITS{1'b1}});
	assign half_c        = (half_ext > count_max_ext) ? COUNT_BITS'(count_max_ext)
	                                                  : COUNT_BITS'(half_ext);
	assign flag_new      = (div_quo >= thresh_q);

	assign div_start = (state_q == ST_COUNT);

	lerm_div #(
		.COUNT_BITS(COUNT_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (product),
		.divisor  (packet_inc),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake outputs.
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = (outcome == OUTCOME_INCOMPLETE) ? ST_DONE : ST_COUNT;
				end
			end
			ST_COUNT:  state_d = ST_DIVIDE;
			ST_DIVIDE: if (div_done) state_d = ST_EVAL;
			ST_EVAL:   state_d = ST_DONE;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Monitor state: counts, stored percentage and anomaly flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_q <= '0;
			error_q  <= '0;
			rate_q   <= '0;
			flag_q   <= 1'b0;
			rose_q   <= 1'b0;
			is_bad_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						is_bad_q <= outcome[1];
						rose_q   <= 1'b0;
					end
				end
				ST_COUNT: begin
					packet_q <= packet_inc;
					error_q  <= error_inc;
				end
				ST_EVAL: begin
					rate_q <= div_quo;
					if (window_full) begin
						flag_q   <= flag_new;
						rose_q   <= flag_new && !flag_q;
						packet_q <= half_c;
						if (error_q > half_c) begin
							error_q <= half_c;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Result register: holds a finished word until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_anom_q <= flag_q;
			out_rose_q <= rose_q;
			out_pct_q  <= rate_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign anomaly       = out_anom_q;
	assign new_alert     = out_rose_q;
	assign error_percent = out_pct_q;

endmodule

// ----- rtl/lerm_checker.sv -----
// Port-level checks for the link error-rate anomaly monitor, bound to the top level.
module lerm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic                            anomaly,
	input logic                            new_alert,
	input logic [lerm_pkg::PCT_W-1:0]      error_percent
);
	import lerm_pkg::*;

	// One word at a time: the input closes right after an accepted word.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input ready stayed high after an accepted word");

	// A new alert is only reported together with a set anomaly flag.
	a_alert_implies_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && new_alert) |-> anomaly)
		else $error("new alert without anomaly flag");

	// The error count never exceeds the packet count, so the percentage stays in range.
	a_percent_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (error_percent <= PCT_W'(PCT_SCALE)))
		else $error("error percentage above one hundred");

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			(out_valid && $stable(anomaly) && $stable(new_alert) && $stable(error_percent)))
		else $error("result word changed while stalled");

endmodule

bind link_error_rate_anomaly_monitor_top lerm_checker u_lerm_checker (.*);
